### design/binary_arithmetic_coder_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the binary arithmetic coder
// Shared property templates used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef BINARY_ARITHMETIC_CODER_UNIT_MACROS_SVH
`define BINARY_ARITHMETIC_CODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BAC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BAC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bac_pkg.sv
// ---------------------------------------------------------------------------
// Binary arithmetic coder package
// Types and codes shared by controller and datapath, and the probability clip helper.
// ---------------------------------------------------------------------------
package bac_pkg;

  localparam int PROB_BITS  = 12;
  localparam int PROB_IN_W  = 12;
  localparam int PROB_MAX   = (1 << PROB_BITS) - 1;
  localparam int CNT_W      = 3;
  localparam logic [CNT_W-1:0] MAX_SHIFTS   = 3'd4;
  localparam logic [CNT_W-1:0] LOADS_START  = 3'd4;
  localparam logic [CNT_W-1:0] FLUSH_LAST   = 3'd3;

  typedef enum logic [2:0] {
    ACT_START_ENC = 3'd0,
    ACT_ENC_BIT   = 3'd1,
    ACT_FLUSH     = 3'd2,
    ACT_START_DEC = 3'd3,
    ACT_DEC_BIT   = 3'd4,
    ACT_LOAD      = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_UPDATE,
    ST_ENC_NORM,
    ST_DEC_NORM,
    ST_FLUSH,
    ST_PLAIN,
    ST_STATUS
  } state_t;

  typedef enum logic [2:0] {
    EK_PLAIN,
    EK_STATUS,
    EK_BIT,
    EK_BYTE,
    EK_FLUSH
  } emit_kind_t;

  typedef struct packed {
    logic       load;
    logic       calc_split;
    logic       apply_split;
    logic       shift;
    logic       flush_shift;
    logic       emit;
    emit_kind_t kind;
  } ctl_cmd_t;

  typedef struct packed {
    logic pend_zero;
    logic renorm;
    logic enc_last;
    logic cnt_last;
    logic out_free;
    logic dec;
  } dp_status_t;

  // Saturate the incoming probability to the coder's precision.
  function automatic logic [PROB_BITS-1:0] prob_clip(input logic [PROB_IN_W-1:0] raw);
    logic [31:0] wide;
    wide = 32'(raw);
    if (wide > 32'(PROB_MAX)) begin
      wide = 32'(PROB_MAX);
    end
    return wide[PROB_BITS-1:0];
  endfunction

endpackage

### design/bac_ctrl.sv
// ---------------------------------------------------------------------------
// Binary arithmetic coder controller
// Sequences one command at a time through load, split, update,
// renormalization, flush and result emission.
// ---------------------------------------------------------------------------
module bac_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [2:0]          action,
  input  bac_pkg::dp_status_t sts,
  output logic                in_ready,
  output bac_pkg::ctl_cmd_t   cmd
);
  import bac_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.kind  = EK_PLAIN;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (action_t'(action))
            ACT_ENC_BIT: state_nxt = ST_SPLIT;
            ACT_FLUSH:   state_nxt = ST_FLUSH;
            ACT_DEC_BIT: state_nxt = sts.pend_zero ? ST_SPLIT : ST_STATUS;
            default:     state_nxt = ST_PLAIN;
          endcase
        end
      end
      ST_SPLIT: begin
        cmd.calc_split = 1'b1;
        state_nxt      = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.apply_split = 1'b1;
        // The datapath remembers which kind of bit this was.
        state_nxt = sts.dec ? ST_DEC_NORM : ST_ENC_NORM;
      end
      ST_ENC_NORM: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.renorm) begin
            cmd.kind  = EK_BYTE;
            cmd.shift = 1'b1;
            if (sts.enc_last) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            cmd.kind  = EK_PLAIN;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DEC_NORM: begin
        if (sts.renorm) begin
          cmd.shift = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = EK_BIT;
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.kind        = EK_FLUSH;
          cmd.flush_shift = 1'b1;
          if (sts.cnt_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_PLAIN: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = EK_PLAIN;
          state_nxt = ST_IDLE;
        end
      end
      ST_STATUS: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = EK_STATUS;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### design/bac_dpath.sv
// ---------------------------------------------------------------------------
// Binary arithmetic coder datapath
// Interval, code word and load count registers, the split multiplier and
// adder, the byte renormalizer and the result register.
// ---------------------------------------------------------------------------
module bac_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bac_pkg::ctl_cmd_t     cmd,
  input  logic [2:0]            action,
  input  logic                  bit_in,
  input  logic [bac_pkg::PROB_IN_W-1:0] probability,
  input  logic [7:0]            in_byte,
  input  logic                  out_ready,
  output bac_pkg::dp_status_t   sts,
  output logic                  out_valid,
  output logic [7:0]            out_byte,
  output logic                  byte_valid,
  output logic                  bit_out,
  output logic [2:0]            bytes_needed,
  output logic                  status,
  output logic                  last
);
  import bac_pkg::*;

  logic [31:0]          low_r, high_r, code_r, mid_r;
  logic [CNT_W-1:0]     pend_r, cnt_r;
  logic                 bit_r, dec_r, dbit_r;
  logic [31:0]          prod_hi_r;
  logic [PROB_BITS-1:0] prod_lo_r;

  logic                 out_valid_r, byte_valid_r, bit_out_r, status_r, last_r;
  logic [7:0]           out_byte_r;
  logic [2:0]           bn_r;

  logic                 byte_valid_nxt, bit_out_nxt, status_nxt, last_nxt;
  logic [7:0]           out_byte_nxt;
  logic [2:0]           bn_nxt;

  logic [31:0]            range;
  logic [PROB_BITS-1:0]   p_clip;
  logic [31:0]            prod_hi;
  logic [2*PROB_BITS-1:0] prod_lo;
  logic                   take_one;

  assign range    = high_r - low_r;
  assign p_clip   = prob_clip(probability);
  assign prod_hi  = 32'(range[31:PROB_BITS]) * 32'(p_clip);
  assign prod_lo  = (2*PROB_BITS)'(range[PROB_BITS-1:0]) * (2*PROB_BITS)'(p_clip);
  assign take_one = dec_r ? (code_r <= mid_r) : bit_r;

  assign sts.pend_zero = (pend_r == '0);
  assign sts.renorm    = (low_r[31:24] == high_r[31:24]) && (cnt_r != MAX_SHIFTS);
  // Whether the byte shifted out now is the last one for this bit.
  assign sts.enc_last  = !((cnt_r < FLUSH_LAST) && (low_r[23:16] == high_r[23:16]));
  assign sts.cnt_last  = (cnt_r == FLUSH_LAST);
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.dec       = dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= '1;
      code_r <= '0;
      pend_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd.load) begin
        cnt_r     <= '0;
        bit_r     <= bit_in;
        dec_r     <= (action_t'(action) == ACT_DEC_BIT);
        prod_hi_r <= prod_hi;
        prod_lo_r <= prod_lo[2*PROB_BITS-1:PROB_BITS];
        case (action_t'(action))
          ACT_START_ENC: begin
            low_r  <= '0;
            high_r <= '1;
          end
          ACT_START_DEC: begin
            low_r  <= '0;
            high_r <= '1;
            code_r <= '0;
            pend_r <= LOADS_START;
          end
          ACT_LOAD: begin
            if (pend_r != '0) begin
              code_r <= {code_r[23:0], in_byte};
              pend_r <= pend_r - CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
      if (cmd.calc_split) begin
        mid_r <= low_r + prod_hi_r + 32'(prod_lo_r);
      end
      if (cmd.apply_split) begin
        dbit_r <= take_one;
        if (take_one) begin
          high_r <= mid_r;
        end else begin
          low_r <= mid_r + 32'd1;
        end
      end
      if (cmd.shift) begin
        low_r  <= {low_r[23:0], 8'h00};
        high_r <= {high_r[23:0], 8'hff};
        cnt_r  <= cnt_r + CNT_W'(1);
      end
      if (cmd.flush_shift) begin
        low_r <= {low_r[23:0], 8'h00};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.emit && (cmd.kind == EK_BIT)) begin
        pend_r <= cnt_r;
      end
    end
  end

  // Result register: holds one finished result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_byte_nxt   = 8'h00;
    byte_valid_nxt = 1'b0;
    bit_out_nxt    = 1'b0;
    bn_nxt         = pend_r;
    status_nxt     = 1'b0;
    last_nxt       = 1'b1;
    case (cmd.kind)
      EK_STATUS: status_nxt = 1'b1;
      EK_BIT: begin
        bit_out_nxt = dbit_r;
        bn_nxt      = cnt_r;
      end
      EK_BYTE: begin
        out_byte_nxt   = high_r[31:24];
        byte_valid_nxt = 1'b1;
        last_nxt       = sts.enc_last;
      end
      EK_FLUSH: begin
        out_byte_nxt   = low_r[31:24];
        byte_valid_nxt = 1'b1;
        last_nxt       = sts.cnt_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r   <= out_byte_nxt;
      byte_valid_r <= byte_valid_nxt;
      bit_out_r    <= bit_out_nxt;
      bn_r         <= bn_nxt;
      status_r     <= status_nxt;
      last_r       <= last_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign byte_valid   = byte_valid_r;
  assign bit_out      = bit_out_r;
  assign bytes_needed = bn_r;
  assign status       = status_r;
  assign last         = last_r;

endmodule

### design/binary_arithmetic_coder_unit.sv
// ---------------------------------------------------------------------------
// Binary arithmetic coder unit
// Carryless 32-bit binary arithmetic encoder and decoder with a stream
// command input and a stream result output.
// ---------------------------------------------------------------------------
// One command is in flight at a time; in_tready is high only while the
// controller is idle. Start encode, start decode, load byte, unused codes and
// a decode bit refused for pending loads go straight to emitting a result.
// Encode and decode bits pass through the registered split multiply, the
// 32-bit split adder and compare, and the renormalizer that moves one byte
// per cycle (when encoding, only while the result port is free); flush
// emits the low word a byte at a time. A stalled result port holds emission.
// A finished result sits in an output register, so the next command can be
// taken while it waits.
module binary_arithmetic_coder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // bit_in, probability[11:0], in_byte[7:0], zero pad
  input  logic [2:0]  in_tuser,   // action[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_byte[7:0], bit_out, bytes_needed[2:0], status, pad
  output logic        out_tuser,  // byte_valid
  output logic        out_tlast
);
  import bac_pkg::*;

  `include "binary_arithmetic_coder_unit_macros.svh"

  ctl_cmd_t   cmd;
  dp_status_t sts;
  logic [7:0] out_byte;
  logic       byte_valid, bit_out, status, last;
  logic [2:0] bytes_needed;

  bac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .action   (in_tuser),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  bac_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .action       (in_tuser),
    .bit_in       (in_tdata[0]),
    .probability  (in_tdata[12:1]),
    .in_byte      (in_tdata[20:13]),
    .out_ready    (out_tready),
    .sts          (sts),
    .out_valid    (out_tvalid),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .bit_out      (bit_out),
    .bytes_needed (bytes_needed),
    .status       (status),
    .last         (last)
  );

  assign out_tdata = {3'b000, status, bytes_needed, bit_out, out_byte};
  assign out_tuser = byte_valid;
  assign out_tlast = last;

  `BAC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready,
                   "second command taken while busy")
  `BAC_ASSERT_NOW(a_error_result_clean, clk, rst_n, out_tvalid && status,
                  out_tlast && !byte_valid && !bit_out, "error result carries data")
  `BAC_ASSERT_NOW(a_loads_bounded, clk, rst_n, out_tvalid, bytes_needed <= LOADS_START,
                  "pending load count out of range")

endmodule

### test/tb_top.sv
// ---------------------------------------------------------------------------
// Binary arithmetic coder unit testbench
// Streams start, encode, flush, decode and load commands into the coder,
// predicts every result item with a behavioral copy of the interval coder and
// checks each output transfer against it, under random idling on both sides.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bac_pkg::*;

  localparam logic [2:0]  ACT_SPARE_A = 3'd6;
  localparam logic [2:0]  ACT_SPARE_B = 3'd7;
  localparam logic [31:0] TOP_MASK    = 32'hff00_0000;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          ITEM_COUNT  = 380;
  localparam int          LONG_HOLD   = 400;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       bit_out;
    logic [2:0] bytes_needed;
    logic       status;
    logic       last;
  } coder_result_t;

  localparam coder_result_t PLAIN_DONE = '{8'h00, 1'b0, 1'b0, 3'd0, 1'b0, 1'b1};
  localparam coder_result_t NO_WANT    = '0;

  typedef struct {
    logic [2:0]    action;
    logic          bit_in;
    logic [11:0]   prob;
    logic [7:0]    in_byte;
    logic          typed;
    coder_result_t want;
  } cmd_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  binary_arithmetic_coder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // Behavioral copy of the coder state.
  logic [31:0] iv_low = 32'h0;
  logic [31:0] iv_high = 32'hffff_ffff;
  logic [31:0] code_reg = 32'h0;
  logic [2:0]  loads_due = 3'd0;

  coder_result_t coder_out_q[$];
  cmd_row_t      cmd_rows[$];
  int unsigned   errors = 0;
  int unsigned   cycles = 0;
  int unsigned   items_sent = 0;
  int unsigned   burst_left = 0;
  logic          hold_req = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(0, 2);
    if (r < 19) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [11:0] pick_prob();
    case ($urandom_range(0, 11))
      0: return 12'd0;
      1: return 12'd1;
      2: return 12'd4094;
      3: return 12'd4095;
      4: return 12'd2048;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [31:0] split_of(input logic [11:0] p);
    logic [31:0] span;
    logic [31:0] pw;
    span = iv_high - iv_low;
    pw = 32'(p);
    return iv_low + (span >> PROB_BITS) * pw + (((span & 32'(PROB_MAX)) * pw) >> PROB_BITS);
  endfunction

  function automatic void push_result(input logic [7:0] ob, input logic bv, input logic bo,
                                      input logic st, input logic lst);
    coder_result_t r;
    r.out_byte = ob;
    r.byte_valid = bv;
    r.bit_out = bo;
    r.bytes_needed = loads_due;
    r.status = st;
    r.last = lst;
    coder_out_q.push_back(r);
  endfunction

  // Advances the coder state by one command and queues the results it causes.
  function automatic void coder_step(input logic [2:0] act, input logic bit_in,
                                     input logic [11:0] prob_raw, input logic [7:0] in_byte);
    logic [31:0] mid;
    logic [11:0] p;
    logic [7:0]  shifted[4];
    logic        dec;
    int          n;
    p = (int'(prob_raw) > PROB_MAX) ? 12'(PROB_MAX) : prob_raw;
    n = 0;
    case (act)
      ACT_START_ENC: begin
        iv_low = 32'h0;
        iv_high = 32'hffff_ffff;
        push_result(8'h0, 1'b0, 1'b0, 1'b0, 1'b1);
      end
      ACT_ENC_BIT: begin
        mid = split_of(p);
        if (bit_in) iv_high = mid;
        else iv_low = mid + 32'd1;
        while (n < 4 && ((iv_low ^ iv_high) & TOP_MASK) == 32'h0) begin
          shifted[n] = iv_high[31:24];
          iv_low = iv_low << 8;
          iv_high = {iv_high[23:0], 8'hff};
          n++;
        end
        if (n == 0) begin
          push_result(8'h0, 1'b0, 1'b0, 1'b0, 1'b1);
        end
        for (int i = 0; i < n; i++) push_result(shifted[i], 1'b1, 1'b0, 1'b0, i == n - 1);
      end
      ACT_FLUSH: begin
        for (int i = 0; i < 4; i++) begin
          push_result(iv_low[31:24], 1'b1, 1'b0, 1'b0, i == 3);
          iv_low = iv_low << 8;
        end
      end
      ACT_START_DEC: begin
        iv_low = 32'h0;
        iv_high = 32'hffff_ffff;
        code_reg = 32'h0;
        loads_due = LOADS_START;
        push_result(8'h0, 1'b0, 1'b0, 1'b0, 1'b1);
      end
      ACT_DEC_BIT: begin
        if (loads_due != 3'd0) begin
          push_result(8'h0, 1'b0, 1'b0, 1'b1, 1'b1);
        end else begin
          mid = split_of(p);
          dec = (code_reg <= mid);
          if (dec) iv_high = mid;
          else iv_low = mid + 32'd1;
          while (n < 4 && ((iv_low ^ iv_high) & TOP_MASK) == 32'h0) begin
            iv_low = iv_low << 8;
            iv_high = {iv_high[23:0], 8'hff};
            n++;
          end
          loads_due = 3'(n);
          push_result(8'h0, 1'b0, dec, 1'b0, 1'b1);
        end
      end
      ACT_LOAD: begin
        if (loads_due != 3'd0) begin
          code_reg = {code_reg[23:0], in_byte};
          loads_due = loads_due - 3'd1;
        end
        push_result(8'h0, 1'b0, 1'b0, 1'b0, 1'b1);
      end
      default: push_result(8'h0, 1'b0, 1'b0, 1'b0, 1'b1);
    endcase
  endfunction

  // Offers one command after a random gap and predicts it once the transfer
  // completes. A typed expectation replaces the single predicted result.
  task automatic send_cmd(input logic [2:0] act, input logic bit_in, input logic [11:0] prob,
                          input logic [7:0] in_byte, input logic typed,
                          input coder_result_t want);
    int unsigned gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 40) == 0) burst_left = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {3'b000, in_byte, prob, bit_in};
    do @(posedge clk); while (!in_tready);
    coder_step(act, bit_in, prob, in_byte);
    if (typed) begin
      coder_out_q.delete(coder_out_q.size() - 1);
      coder_out_q.push_back(want);
    end
    items_sent++;
  endtask

  task automatic send_rand(input logic [2:0] act, input logic [11:0] prob);
    send_cmd(act, 1'($urandom), prob, 8'($urandom), 1'b0, NO_WANT);
  endtask

  // Receiver: random back-pressure plus one long hold-off on request.
  initial begin
    int unsigned hold;
    int unsigned gap_left;
    logic        hold_done;
    hold = 0;
    gap_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else if (gap_left > 0) begin
        out_tready <= 1'b0;
        gap_left--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) gap_left = pick_gap();
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    coder_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (coder_out_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual data %0h user %0b last %0b",
                 $realtime, out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        want = coder_out_q.pop_front();
        check_field("out_byte", want.out_byte, out_tdata[7:0]);
        check_field("byte_valid", want.byte_valid, out_tuser);
        check_field("bit_out", want.bit_out, out_tdata[8]);
        check_field("bytes_needed", want.bytes_needed, out_tdata[11:9]);
        check_field("status", want.status, out_tdata[12]);
        check_field("last", want.last, out_tlast);
      end
    end
  end

  initial begin
    int unsigned nbits;
    int unsigned pick;
    cmd_row_t    row;
    // Directed commands: extremes of the probability, every action, a decode
    // before the code word is loaded and a load with nothing pending.
    cmd_rows.push_back('{ACT_START_ENC, 1'b0, 12'd0, 8'h00, 1'b1, PLAIN_DONE});
    cmd_rows.push_back('{ACT_ENC_BIT, 1'b1, 12'd4095, 8'h00, 1'b0, NO_WANT});
    cmd_rows.push_back('{ACT_ENC_BIT, 1'b0, 12'd0, 8'hff, 1'b0, NO_WANT});
    cmd_rows.push_back('{ACT_ENC_BIT, 1'b1, 12'd0, 8'h00, 1'b0, NO_WANT});
    cmd_rows.push_back('{ACT_ENC_BIT, 1'b0, 12'd4095, 8'h00, 1'b0, NO_WANT});
    cmd_rows.push_back('{ACT_ENC_BIT, 1'b1, 12'd2048, 8'h00, 1'b0, NO_WANT});
    cmd_rows.push_back('{ACT_ENC_BIT, 1'b0, 12'd1, 8'h00, 1'b0, NO_WANT});
    cmd_rows.push_back('{ACT_FLUSH, 1'b0, 12'd0, 8'h00, 1'b0, NO_WANT});
    cmd_rows.push_back('{ACT_SPARE_A, 1'b1, 12'hfff, 8'hff, 1'b1, PLAIN_DONE});
    cmd_rows.push_back('{ACT_SPARE_B, 1'b0, 12'h000, 8'h00, 1'b1, PLAIN_DONE});
    cmd_rows.push_back('{ACT_LOAD, 1'b1, 12'h000, 8'hff, 1'b1, PLAIN_DONE});
    cmd_rows.push_back('{ACT_START_DEC, 1'b0, 12'd0, 8'h00, 1'b1,
                         '{8'h0, 1'b0, 1'b0, 3'd4, 1'b0, 1'b1}});
    cmd_rows.push_back('{ACT_DEC_BIT, 1'b0, 12'd2048, 8'h00, 1'b1,
                         '{8'h0, 1'b0, 1'b0, 3'd4, 1'b1, 1'b1}});
    cmd_rows.push_back('{ACT_LOAD, 1'b0, 12'd0, 8'ha5, 1'b1,
                         '{8'h0, 1'b0, 1'b0, 3'd3, 1'b0, 1'b1}});
    cmd_rows.push_back('{ACT_LOAD, 1'b0, 12'd0, 8'h00, 1'b1,
                         '{8'h0, 1'b0, 1'b0, 3'd2, 1'b0, 1'b1}});
    cmd_rows.push_back('{ACT_LOAD, 1'b0, 12'd0, 8'hff, 1'b1,
                         '{8'h0, 1'b0, 1'b0, 3'd1, 1'b0, 1'b1}});
    cmd_rows.push_back('{ACT_LOAD, 1'b0, 12'd0, 8'h5a, 1'b1,
                         '{8'h0, 1'b0, 1'b0, 3'd0, 1'b0, 1'b1}});
    cmd_rows.push_back('{ACT_DEC_BIT, 1'b0, 12'd4095, 8'h00, 1'b0, NO_WANT});
    cmd_rows.push_back('{ACT_DEC_BIT, 1'b0, 12'd0, 8'h00, 1'b0, NO_WANT});
    cmd_rows.push_back('{ACT_LOAD, 1'b0, 12'd0, 8'h3c, 1'b0, NO_WANT});
    cmd_rows.push_back('{ACT_DEC_BIT, 1'b1, 12'd2048, 8'h00, 1'b0, NO_WANT});
    cmd_rows.push_back('{ACT_FLUSH, 1'b0, 12'd0, 8'h00, 1'b0, NO_WANT});
    cmd_rows.push_back('{ACT_START_ENC, 1'b0, 12'd0, 8'h00, 1'b0, NO_WANT});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (cmd_rows[i]) begin
      row = cmd_rows[i];
      send_cmd(row.action, row.bit_in, row.prob, row.in_byte, row.typed, row.want);
    end

    // Random part: mostly well-formed encode and decode sessions, some noise.
    while (items_sent < ITEM_COUNT) begin
      if (items_sent >= 150) hold_req = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        send_rand(ACT_START_ENC, pick_prob());
        nbits = $urandom_range(2, 20);
        repeat (nbits) send_rand(ACT_ENC_BIT, pick_prob());
        if ($urandom_range(0, 3) != 0) send_rand(ACT_FLUSH, pick_prob());
      end else if (pick < 8) begin
        send_rand(ACT_START_DEC, pick_prob());
        if ($urandom_range(0, 5) == 0) send_rand(ACT_DEC_BIT, pick_prob());
        while (loads_due != 3'd0) send_rand(ACT_LOAD, pick_prob());
        nbits = $urandom_range(4, 16);
        repeat (nbits) begin
          send_rand(ACT_DEC_BIT, pick_prob());
          // Occasionally decode again before the needed bytes are in.
          if (loads_due != 3'd0 && $urandom_range(0, 7) == 0) begin
            send_rand(ACT_DEC_BIT, pick_prob());
          end
          while (loads_due != 3'd0) send_rand(ACT_LOAD, pick_prob());
          if ($urandom_range(0, 9) == 0) send_rand(ACT_LOAD, pick_prob());
        end
      end else begin
        repeat ($urandom_range(1, 4)) send_rand(3'($urandom_range(0, 7)), 12'($urandom));
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (coder_out_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && coder_out_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### binary_arithmetic_coder_unit.f
+incdir+design
design/bac_pkg.sv
design/bac_ctrl.sv
design/bac_dpath.sv
design/binary_arithmetic_coder_unit.sv
test/tb_top.sv
